/* src/mpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_pkg
// shared types and constants of the mouse packet decoder
// ----------------------------------------------------------------------------
package mpd_pkg;

   localparam int unsigned ByteWidth        = 8;
   localparam int unsigned TimeWidth        = 63;
   localparam int unsigned WindowWidth      = 32;
   localparam int unsigned ButtonWidth      = 3;
   localparam int unsigned DeltaWidth       = 9;
   localparam int unsigned CountWidth       = 8;
   localparam int unsigned ReqDataWidth     = 72;
   localparam int unsigned RspDataWidth     = 96;

   localparam logic [WindowWidth-1:0] ClickWindowReset = 32'd500000;
   localparam logic [CountWidth-1:0]  CountMax         = 8'hff;

   // bit positions in the first byte of a packet
   localparam int unsigned XSignBit = 4;
   localparam int unsigned YSignBit = 5;

   // position of the next byte within its packet
   typedef enum logic [1:0] {
      PhaseFirst  = 2'd0,
      PhaseSecond = 2'd1,
      PhaseThird  = 2'd2
   } phase_type;

   // decoded fields of one complete packet
   typedef struct packed {
      logic [ButtonWidth-1:0]       buttons;
      logic signed [DeltaWidth-1:0] x_delta;
      logic signed [DeltaWidth-1:0] y_delta;
   } packet_type;

   // status from the byte assembler
   typedef struct packed {
      logic third_byte;   // the next byte closes a packet
   } asm_status_type;

endpackage
`default_nettype wire

/* src/mouse_packet_decoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_packet_decoder_core
// three-byte mouse packet decoder with multi-click counting
// ----------------------------------------------------------------------------
// Each req transaction carries one mouse byte and its microsecond timestamp.
// Bytes are grouped into packets of three; the third byte of a packet yields
// one rsp transaction with the buttons, the sign-extended x and y deltas, the
// click count and the third byte's time. The block takes one byte per clock:
// the first two bytes of a packet are always accepted, and the third waits
// only while the single result register still holds an untaken result. The
// result appears on rsp in the cycle after its third byte is accepted. The click
// count rises on a press edge (all buttons released before, any pressed now)
// that comes less than click_window microseconds after the previous press
// edge, otherwise restarts at one, and stays at 255 once there. Sync and
// overflow bits of the first byte are not checked. The click window register
// is written through csr and should only change while the block is idle.
// ----------------------------------------------------------------------------
module mouse_packet_decoder_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // data_byte [7:0], now_time [70:8], zero [71]
   input  wire logic [mpd_pkg::ReqDataWidth-1:0]  req_tdata,
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // buttons [2:0], x_delta [11:3], y_delta [20:12], click_count [28:21],
   // event_time [91:29], zero [95:92]
   output logic      [mpd_pkg::RspDataWidth-1:0]  rsp_tdata,
   // click window register
   input  wire logic                              csr_wr_en,
   input  wire logic [mpd_pkg::WindowWidth-1:0]   csr_wr_data
);

   localparam int unsigned PadWidth = mpd_pkg::RspDataWidth - mpd_pkg::ButtonWidth
                                    - 2 * mpd_pkg::DeltaWidth - mpd_pkg::CountWidth
                                    - mpd_pkg::TimeWidth;

   logic [mpd_pkg::WindowWidth-1:0] click_window_ff, click_window_in;
   logic [mpd_pkg::ByteWidth-1:0]   data_byte;
   logic [mpd_pkg::TimeWidth-1:0]   now_time;
   logic                            req_fire;
   logic                            packet_done;
   logic                            rsp_space;
   logic [mpd_pkg::CountWidth-1:0]  click_count;
   logic [mpd_pkg::RspDataWidth-1:0] rsp_data;
   mpd_pkg::asm_status_type         asm_status;
   mpd_pkg::packet_type             packet;

   // unpack the request fields
   assign data_byte = req_tdata[mpd_pkg::ByteWidth-1:0];
   assign now_time  = req_tdata[mpd_pkg::ByteWidth +: mpd_pkg::TimeWidth];

   // result register is free, or empties this cycle
   assign rsp_space   = !rsp_tvalid || rsp_tready;
   // only the packet-closing byte needs room for a result
   assign req_tready  = !asm_status.third_byte || rsp_space;
   assign req_fire    = req_tvalid && req_tready;
   assign packet_done = req_fire && asm_status.third_byte;

   // click window register
   assign click_window_in = csr_wr_en ? csr_wr_data : click_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_window_ff <= mpd_pkg::ClickWindowReset;
      end else begin
         click_window_ff <= click_window_in;
      end
   end

   mpd_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_fire),
      .data_byte  (data_byte),
      .status     (asm_status),
      .packet     (packet)
   );

   mpd_click_tracker u_click_tracker (
      .clock        (clock),
      .reset        (reset),
      .packet_done  (packet_done),
      .buttons      (packet.buttons),
      .now_time     (now_time),
      .click_window (click_window_ff),
      .click_count  (click_count)
   );

   // pack the result fields, lowest first
   assign rsp_data = {{PadWidth{1'b0}}, now_time, click_count,
                      packet.y_delta, packet.x_delta, packet.buttons};

   mpd_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (packet_done),
      .load_data  (rsp_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* src/mpd_assembler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_assembler
// collects bytes into three-byte packets and decodes buttons and deltas
// ----------------------------------------------------------------------------
module mpd_assembler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          byte_valid,
   input  wire logic [mpd_pkg::ByteWidth-1:0] data_byte,
   output mpd_pkg::asm_status_type            status,
   output mpd_pkg::packet_type                packet
);

   mpd_pkg::phase_type                phase_ff, phase_in;
   logic [mpd_pkg::ByteWidth-1:0]     first_byte_ff, first_byte_in;
   logic [mpd_pkg::ByteWidth-1:0]     second_byte_ff, second_byte_in;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            mpd_pkg::PhaseSecond: begin
               second_byte_in = data_byte;
               phase_in       = mpd_pkg::PhaseThird;
            end
            mpd_pkg::PhaseThird: begin
               phase_in = mpd_pkg::PhaseFirst;
            end
            default: begin
               // the unused phase code behaves as the first byte
               first_byte_in = data_byte;
               phase_in      = mpd_pkg::PhaseSecond;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      status.third_byte = (phase_ff == mpd_pkg::PhaseThird);
      packet.buttons    = first_byte_ff[mpd_pkg::ButtonWidth-1:0];
      packet.x_delta    = {first_byte_ff[mpd_pkg::XSignBit], second_byte_ff};
      packet.y_delta    = {first_byte_ff[mpd_pkg::YSignBit], data_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= mpd_pkg::PhaseFirst;
         first_byte_ff  <= '0;
         second_byte_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         first_byte_ff  <= first_byte_in;
         second_byte_ff <= second_byte_in;
      end
   end

endmodule
`default_nettype wire

/* src/mpd_click_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_click_tracker
// counts presses that follow each other within the click window
// ----------------------------------------------------------------------------
module mpd_click_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             packet_done,
   input  wire logic [mpd_pkg::ButtonWidth-1:0]  buttons,
   input  wire logic [mpd_pkg::TimeWidth-1:0]    now_time,
   input  wire logic [mpd_pkg::WindowWidth-1:0]  click_window,
   output logic      [mpd_pkg::CountWidth-1:0]   click_count
);

   logic [mpd_pkg::ButtonWidth-1:0] prev_buttons_ff, prev_buttons_in;
   logic [mpd_pkg::TimeWidth-1:0]   last_press_ff, last_press_in;
   logic [mpd_pkg::CountWidth-1:0]  clicks_ff, clicks_in;
   logic [mpd_pkg::TimeWidth:0]     window_end;
   logic                            press_edge;
   logic                            in_window;

   // one bit wider so the sum cannot wrap
   assign window_end = {1'b0, last_press_ff}
                     + {{(mpd_pkg::TimeWidth + 1 - mpd_pkg::WindowWidth){1'b0}}, click_window};
   assign in_window  = window_end > {1'b0, now_time};
   assign press_edge = (buttons != '0) && (prev_buttons_ff == '0);

   always_comb begin
      clicks_in       = clicks_ff;
      last_press_in   = last_press_ff;
      prev_buttons_in = prev_buttons_ff;
      if (packet_done) begin
         prev_buttons_in = buttons;
         if (press_edge) begin
            last_press_in = now_time;
            priority if (!in_window) begin
               clicks_in = mpd_pkg::CountWidth'(1);
            end else if (clicks_ff != mpd_pkg::CountMax) begin
               clicks_in = clicks_ff + mpd_pkg::CountWidth'(1);
            end
         end
      end
   end

   assign click_count = clicks_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
         last_press_ff   <= '0;
         clicks_ff       <= '0;
      end else begin
         prev_buttons_ff <= prev_buttons_in;
         last_press_ff   <= last_press_in;
         clicks_ff       <= clicks_in;
      end
   end

endmodule
`default_nettype wire

/* src/mpd_rsp_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_rsp_reg
// result register holding one decoded packet until it is taken
// ----------------------------------------------------------------------------
module mpd_rsp_reg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load,
   input  wire logic [mpd_pkg::RspDataWidth-1:0] load_data,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [mpd_pkg::RspDataWidth-1:0] rsp_tdata
);

   logic                             valid_ff, valid_in;
   logic [mpd_pkg::RspDataWidth-1:0] data_ff, data_in;

   assign valid_in = load || (valid_ff && !rsp_tready);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire
